FILE: rtl/core/vna_pkg.sv
package vna_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int VIDX_W = 10;
  localparam int ADDR_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int ACC_W = 48;
  localparam int POS_W = 48;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_TRI   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_WR,
    ST_TRD0,
    ST_TRD1,
    ST_TRD2,
    ST_TRD3,
    ST_EDGE,
    ST_MUL,
    ST_ACC_RD,
    ST_ACC_WAIT,
    ST_ACC_WR,
    ST_RD_RD,
    ST_RD_WAIT,
    ST_NORM_SHIFT,
    ST_NORM_SQ,
    ST_NORM_SQRT,
    ST_NORM_DIV,
    ST_OUT
  } state_t;

  // saturating add of a 48-bit accumulator and a sign-extended delta
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] d);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {d[ACC_W-1], d};
    if (s[ACC_W] != s[ACC_W-1])
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    else
      sat_add = s[ACC_W-1:0];
  endfunction

endpackage

FILE: rtl/core/vna_ram.sv
module vna_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/vna_norm.sv
module vna_norm
  import vna_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] ax,
  input  logic signed [ACC_W-1:0] ay,
  input  logic signed [ACC_W-1:0] az,
  output logic                    done,
  output logic [15:0]             nx,
  output logic [15:0]             ny,
  output logic [15:0]             nz,
  output logic                    degen
);
  typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_ROOT, N_DIV, N_DONE} nst_t;

  nst_t nst_r, nst_nxt;
  logic [ACC_W-1:0] m_r [3];
  logic [2:0]       neg_r;
  logic [50:0]      s_r;
  logic [25:0]      res_r;
  logic [50:0]      rem_r;
  logic [4:0]       cnt_r;
  logic [1:0]       idx_r;
  logic [38:0]      num_r;
  logic [25:0]      q_r;
  logic [15:0]      nout_r [3];
  logic             degen_r;

  logic [ACC_W-1:0] mx;
  logic [ACC_W-1:0] mag [3];
  logic signed [ACC_W-1:0] cin [3];
  logic [50:0] trial;
  logic [25:0] rq;
  logic [39:0] dtrial;
  logic [25:0] qf;

  assign cin[0] = ax;
  assign cin[1] = ay;
  assign cin[2] = az;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = cin[i][ACC_W-1] ? ACC_W'(-cin[i]) : cin[i];
    end
    mx = m_r[0];
    if (m_r[1] > mx) mx = m_r[1];
    if (m_r[2] > mx) mx = m_r[2];
    // sum of squares is below 2^50, so its bit pairs start at bit 49
    trial = {rem_r[48:0], s_r[49:48]} - {23'd0, res_r, 2'b01};
    rq = res_r >> 1;
    dtrial = {rem_r[38:0], num_r[38]} - {14'd0, res_r};
    qf = q_r;
  end

  always_comb begin
    nst_nxt = nst_r;
    case (nst_r)
      N_IDLE:  if (start) nst_nxt = N_SHIFT;
      N_SHIFT: begin
        if (mx == '0) nst_nxt = N_DONE;
        else if (mx < (ACC_W'(1) << 24) && mx >= (ACC_W'(1) << 23)) nst_nxt = N_SQ;
      end
      N_SQ:    nst_nxt = N_ROOT;
      N_ROOT:  if (cnt_r == 5'd24) nst_nxt = N_DIV;
      N_DIV:   if (cnt_r == 5'd26 && idx_r == 2'd2) nst_nxt = N_DONE;
      N_DONE:  nst_nxt = N_IDLE;
      default: nst_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nst_r <= N_IDLE;
    end else begin
      nst_r <= nst_nxt;
    end
    case (nst_r)
      N_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            m_r[i] <= mag[i];
            neg_r[i] <= cin[i][ACC_W-1];
          end
          degen_r <= 1'b0;
          idx_r <= '0;
          cnt_r <= '0;
        end
      end
      N_SHIFT: begin
        if (mx == '0) begin
          degen_r <= 1'b1;
          for (int i = 0; i < 3; i++) nout_r[i] <= '0;
        end else if (mx >= (ACC_W'(1) << 24)) begin
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
        end else if (mx < (ACC_W'(1) << 23)) begin
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
        end
      end
      N_SQ: begin
        // squares are 48 bits max each, one shared multiply over three steps would also do
        s_r <= 51'(m_r[0][23:0] * m_r[0][23:0]) + 51'(m_r[1][23:0] * m_r[1][23:0])
             + 51'(m_r[2][23:0] * m_r[2][23:0]);
        res_r <= '0;
        rem_r <= '0;
        cnt_r <= '0;
      end
      N_ROOT: begin
        // one result bit per cycle
        if (!trial[50]) begin
          rem_r <= trial;
          res_r <= {res_r[24:0], 1'b1};
        end else begin
          rem_r <= {rem_r[48:0], s_r[49:48]};
          res_r <= {res_r[24:0], 1'b0};
        end
        s_r <= {s_r[48:0], 2'b00};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd24) begin
          cnt_r <= '0;
          rem_r <= '0;
          // before its last bit lands, res_r already equals the root halved
          num_r <= {1'b0, m_r[0][23:0], 14'd0} + 39'(res_r);
          q_r <= '0;
        end
      end
      N_DIV: begin
        // restoring divide, one quotient bit per cycle, 39 bits reduced by skipping high zeros
        if (cnt_r == 5'd26) begin
          nout_r[idx_r] <= neg_r[idx_r] ? 16'(-qf) : qf[15:0];
          idx_r <= idx_r + 2'd1;
          cnt_r <= '0;
          rem_r <= '0;
          q_r <= '0;
          num_r <= {1'b0, m_r[(idx_r == 2'd0) ? 1 : 2][23:0], 14'd0} + 39'(rq);
        end else begin
          if (cnt_r == 5'd0) begin
            // top 14 bits of the numerator are below r, preload them
            rem_r <= 51'(num_r[38:25]);
            num_r <= {num_r[24:0], 14'd0};
            cnt_r <= 5'd1;
          end else begin
            if (!dtrial[39]) begin
              rem_r <= 51'(dtrial);
              q_r <= {q_r[24:0], 1'b1};
            end else begin
              rem_r <= {rem_r[49:0], num_r[38]};
              q_r <= {q_r[24:0], 1'b0};
            end
            num_r <= {num_r[37:0], 1'b0};
            cnt_r <= cnt_r + 5'd1;
          end
        end
      end
      default: ;
    endcase
  end

  assign done  = (nst_r == N_DONE);
  assign nx    = nout_r[0];
  assign ny    = nout_r[1];
  assign nz    = nout_r[2];
  assign degen = degen_r;
endmodule

FILE: rtl/core/vertex_normal_accumulator_top.sv
// area-weighted vertex normal accumulator. cmd 0 stores a Q8.8 vertex position and clears its
// accumulator, cmd 1 adds the cross product of a triangle's edges into its three corners'
// saturating 48-bit accumulators, cmd 2 returns one vertex's accumulator normalized to Q1.14
// with a degenerate flag. one word at a time: a write is done in ST_WR; a triangle takes
// three position reads, one product step and three read-modify-writes on the accumulator ram;
// a read takes the 25-step bit-serial square root, the three bit-serial divides in the
// normalizer and the alignment shifts (one bit per cycle, up to 24 bits), and a zero sum skips
// the root and the divides. the output word sits in a register so the next word is taken while it
// waits; a read that finishes while that register is still full waits for it. cmd 3 is dropped.
module vertex_normal_accumulator_top
  import vna_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cmd, vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c, pad
  input  logic [95:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // normal_x, normal_y, normal_z
  output logic [47:0]  out_tdata,
  // degenerate
  output logic         out_tuser
);
  state_t st_r, st_nxt;

  logic [95:0] word_r;
  logic [1:0]  k_r;
  logic signed [16:0] e1_r [3];
  logic signed [16:0] e2_r [3];
  logic signed [15:0] pa_r [3];
  logic signed [ACC_W-1:0] n_r [3];
  logic        obusy_r;
  logic [47:0] odata_r;
  logic        odeg_r;

  // ram ports
  logic             pwe, awe;
  logic [ADDR_W-1:0] pwa, pra, awa, ara;
  logic [POS_W-1:0]  pwd, prd;
  logic [3*ACC_W-1:0] awd, ard;

  logic [VIDX_W-1:0] vi, ca, cb, cc, kidx;
  cmd_t cmd;
  logic ok_tri, ok_vi;
  logic nstart, ndone;
  logic [15:0] nx, ny, nz;
  logic ndeg;

  assign cmd = cmd_t'(word_r[1:0]);
  assign vi  = word_r[11:2];
  assign ca  = word_r[69:60];
  assign cb  = word_r[79:70];
  assign cc  = word_r[89:80];
  assign ok_vi  = 32'(vi) < VERTEX_COUNT;
  assign ok_tri = 32'(ca) < VERTEX_COUNT && 32'(cb) < VERTEX_COUNT && 32'(cc) < VERTEX_COUNT;
  assign kidx = (k_r == 2'd0) ? ca : (k_r == 2'd1) ? cb : cc;

  vna_ram #(.WIDTH(POS_W), .DEPTH(VERTEX_COUNT)) u_pos (
    .clk(clk), .we(pwe), .waddr(pwa), .wdata(pwd), .raddr(pra), .rdata(prd));
  vna_ram #(.WIDTH(3*ACC_W), .DEPTH(VERTEX_COUNT)) u_acc (
    .clk(clk), .we(awe), .waddr(awa), .wdata(awd), .raddr(ara), .rdata(ard));

  vna_norm u_norm (
    .clk(clk), .rst_n(rst_n), .start(nstart),
    .ax(ard[ACC_W-1:0]), .ay(ard[2*ACC_W-1:ACC_W]), .az(ard[3*ACC_W-1:2*ACC_W]),
    .done(ndone), .nx(nx), .ny(ny), .nz(nz), .degen(ndeg));

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_tvalid) st_nxt = ST_WR;
      ST_WR: begin
        case (cmd)
          CMD_WRITE: st_nxt = ST_IDLE;
          CMD_TRI:   st_nxt = ok_tri ? ST_TRD0 : ST_IDLE;
          CMD_READ:  st_nxt = ok_vi ? ST_RD_RD : ST_OUT;
          default:   st_nxt = ST_IDLE;
        endcase
      end
      ST_TRD0:     st_nxt = ST_TRD1;
      ST_TRD1:     st_nxt = ST_TRD2;
      ST_TRD2:     st_nxt = ST_TRD3;
      ST_TRD3:     st_nxt = ST_EDGE;
      ST_EDGE:     st_nxt = ST_MUL;
      ST_MUL:      st_nxt = ST_ACC_RD;
      ST_ACC_RD:   st_nxt = ST_ACC_WAIT;
      ST_ACC_WAIT: st_nxt = ST_ACC_WR;
      ST_ACC_WR:   st_nxt = (k_r == 2'd2) ? ST_IDLE : ST_ACC_RD;
      ST_RD_RD:    st_nxt = ST_RD_WAIT;
      ST_RD_WAIT:  st_nxt = ST_NORM_SHIFT;
      ST_NORM_SHIFT: st_nxt = ST_NORM_SQ;
      ST_NORM_SQ:  if (ndone) st_nxt = ST_OUT;
      ST_OUT:      if (!obusy_r) st_nxt = ST_IDLE;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  // outputs to rams and normalizer
  always_comb begin
    pwe = 1'b0; pwa = vi[ADDR_W-1:0]; pwd = word_r[59:12];
    pra = ca[ADDR_W-1:0];
    awe = 1'b0; awa = kidx[ADDR_W-1:0]; awd = '0;
    ara = kidx[ADDR_W-1:0];
    nstart = 1'b0;
    case (st_r)
      ST_WR: begin
        if (cmd == CMD_WRITE && ok_vi) begin
          pwe = 1'b1;
          awe = 1'b1;
          awa = vi[ADDR_W-1:0];
        end
      end
      ST_TRD0: pra = ca[ADDR_W-1:0];
      ST_TRD1: pra = cb[ADDR_W-1:0];
      ST_TRD2: pra = cc[ADDR_W-1:0];
      ST_ACC_WR: begin
        awe = 1'b1;
        awd = {sat_add(ard[3*ACC_W-1:2*ACC_W], n_r[2]),
               sat_add(ard[2*ACC_W-1:ACC_W], n_r[1]),
               sat_add(ard[ACC_W-1:0], n_r[0])};
      end
      ST_RD_RD, ST_RD_WAIT: ara = vi[ADDR_W-1:0];
      ST_NORM_SHIFT: begin
        ara = vi[ADDR_W-1:0];
        nstart = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      obusy_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_tvalid && out_tready) obusy_r <= 1'b0;
      if (st_r == ST_OUT && !obusy_r) obusy_r <= 1'b1;
    end
    if (st_r == ST_IDLE && in_tvalid) word_r <= in_tdata;
    case (st_r)
      ST_WR: k_r <= '0;
      ST_TRD2: for (int i = 0; i < 3; i++) pa_r[i] <= prd[16*i +: 16];
      ST_TRD3: for (int i = 0; i < 3; i++)
        e1_r[i] <= 17'(signed'(prd[16*i +: 16])) - 17'(pa_r[i]);
      ST_EDGE: for (int i = 0; i < 3; i++)
        e2_r[i] <= 17'(signed'(prd[16*i +: 16])) - 17'(pa_r[i]);
      ST_MUL: begin
        n_r[0] <= ACC_W'(e1_r[1] * e2_r[2]) - ACC_W'(e1_r[2] * e2_r[1]);
        n_r[1] <= ACC_W'(e1_r[2] * e2_r[0]) - ACC_W'(e1_r[0] * e2_r[2]);
        n_r[2] <= ACC_W'(e1_r[0] * e2_r[1]) - ACC_W'(e1_r[1] * e2_r[0]);
      end
      ST_ACC_WR: k_r <= k_r + 2'd1;
      ST_OUT: begin
        if (!obusy_r) begin
          if (ok_vi) begin
            odata_r <= {nz, ny, nx};
            odeg_r <= ndeg;
          end else begin
            odata_r <= '0;
            odeg_r <= 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = obusy_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = odeg_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("accepted word while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_acc_wr: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_ACC_WR |-> $past(st_r) == ST_ACC_WAIT) else $error("accum write out of order");
endmodule

FILE: tb/vna_checker.sv
`timescale 1ns / 100ps
// watches both channels, keeps its own copy of the position and accumulator stores,
// predicts every normal read and compares it with what comes out
module vna_checker
  import vna_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending
);

  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -64'sh0000_7FFF_FFFF_FFFF - 1;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               degenerate;
  } normal_t;

  logic signed [15:0] vert_pos [VERTEX_COUNT][3];
  longint             vert_acc [VERTEX_COUNT][3];
  normal_t            normal_q [$];

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic longint sat48(input longint s);
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // align largest magnitude into [2^23, 2^24), then divide by the rounded-down root
  function automatic normal_t unit_normal(input longint a0, input longint a1, input longint a2);
    longint          c [3];
    longint unsigned m [3];
    longint unsigned mx, s, r, q;
    normal_t         n;
    c[0] = a0;
    c[1] = a1;
    c[2] = a2;
    for (int i = 0; i < 3; i++) m[i] = (c[i] < 0) ? -c[i] : c[i];
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    n = '0;
    if (mx == 0) begin
      n.degenerate = 1'b1;
      return n;
    end
    while (mx >= (64'h1 << 24)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'h1 << 23)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    r = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 14) + (r >> 1)) / r;
      if (c[i] < 0) q = -q;
      if (i == 0) n.x = q[15:0];
      else if (i == 1) n.y = q[15:0];
      else n.z = q[15:0];
    end
    return n;
  endfunction

  task automatic take_command(input logic [95:0] w);
    cmd_t   cmd;
    int     vi;
    int     k [3];
    longint e1 [3], e2 [3], cr [3];
    cmd = cmd_t'(w[1:0]);
    vi = int'(w[11:2]);
    k[0] = int'(w[69:60]);
    k[1] = int'(w[79:70]);
    k[2] = int'(w[89:80]);
    case (cmd)
      CMD_WRITE: begin
        vert_pos[vi][0] = w[27:12];
        vert_pos[vi][1] = w[43:28];
        vert_pos[vi][2] = w[59:44];
        for (int i = 0; i < 3; i++) vert_acc[vi][i] = 0;
      end
      CMD_TRI: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] = longint'(vert_pos[k[1]][i]) - longint'(vert_pos[k[0]][i]);
          e2[i] = longint'(vert_pos[k[2]][i]) - longint'(vert_pos[k[0]][i]);
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        // corners updated in order, so repeated corners add more than once
        for (int j = 0; j < 3; j++)
          for (int i = 0; i < 3; i++)
            vert_acc[k[j]][i] = sat48(vert_acc[k[j]][i] + cr[i]);
      end
      CMD_READ: normal_q = {normal_q, unit_normal(vert_acc[vi][0], vert_acc[vi][1],
                                                  vert_acc[vi][2])};
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    normal_t exp_n;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (normal_q.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          exp_n = normal_q.pop_front();
          if (out_tdata[15:0] !== exp_n.x)
            report($sformatf("normal_x got %0d want %0d", $signed(out_tdata[15:0]), exp_n.x));
          if (out_tdata[31:16] !== exp_n.y)
            report($sformatf("normal_y got %0d want %0d", $signed(out_tdata[31:16]), exp_n.y));
          if (out_tdata[47:32] !== exp_n.z)
            report($sformatf("normal_z got %0d want %0d", $signed(out_tdata[47:32]), exp_n.z));
          if (out_tuser !== exp_n.degenerate)
            report($sformatf("degenerate got %b want %b", out_tuser, exp_n.degenerate));
        end
      end
      if (in_tvalid && in_tready) take_command(in_tdata);
      pending = normal_q.size();
    end
  end

endmodule

FILE: tb/tb_vertex_normal_accumulator_top.sv
`timescale 1ns / 100ps
// stimulus and verdict; the checker beside the block does all prediction
module tb_vertex_normal_accumulator_top;
  import vna_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;   // cmd, vertex_index, pos_x, pos_y, pos_z, corner_a/b/c, pad
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // normal_x, normal_y, normal_z
  logic        out_tuser;  // degenerate
  int          fail_count;
  int          pending;

  // percent of cycles each side idles, set per phase
  int          send_idle_pct;
  int          recv_stall_pct;

  // vertices written so far; triangles and reads only touch these
  int          live_verts [$];
  bit          is_live [VERTEX_COUNT];

  typedef struct {
    cmd_t               cmd;
    logic [9:0]         vidx;
    logic signed [15:0] px, py, pz;
    logic [9:0]         ca, cb, cc;
  } command_t;

  vertex_normal_accumulator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  vna_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver back-pressure, one decision per falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // hard stop well past the slowest legal run
  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // random filler everywhere so unused fields toggle too
  function automatic command_t random_command(input cmd_t cmd);
    command_t c;
    c.cmd = cmd;
    c.vidx = 10'($urandom);
    c.px = 16'($urandom);
    c.py = 16'($urandom);
    c.pz = 16'($urandom);
    c.ca = 10'($urandom);
    c.cb = 10'($urandom);
    c.cc = 10'($urandom);
    return c;
  endfunction

  // hold the word until the block takes it; sender gaps come first
  task automatic send(input command_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, c.cc, c.cb, c.ca, c.pz, c.py, c.px, c.vidx, c.cmd};
    do @(posedge clk); while (!in_tready);
    if (c.cmd == CMD_WRITE && !is_live[c.vidx]) begin
      is_live[c.vidx] = 1'b1;
      live_verts = {live_verts, int'(c.vidx)};
    end
    @(negedge clk);
  endtask

  task automatic write_vertex(input int idx, input int x, input int y, input int z);
    command_t c;
    c = random_command(CMD_WRITE);
    c.vidx = 10'(idx);
    c.px = 16'(x);
    c.py = 16'(y);
    c.pz = 16'(z);
    send(c);
  endtask

  task automatic add_triangle(input int a, input int b, input int cn);
    command_t c;
    c = random_command(CMD_TRI);
    c.ca = 10'(a);
    c.cb = 10'(b);
    c.cc = 10'(cn);
    send(c);
  endtask

  task automatic read_normal(input int idx);
    command_t c;
    c = random_command(CMD_READ);
    c.vidx = 10'(idx);
    send(c);
  endtask

  function automatic int pick_live();
    return live_verts[$urandom_range(0, live_verts.size() - 1)];
  endfunction

  // mostly small coordinates, sometimes full range
  function automatic int random_coord();
    if ($urandom_range(0, 3) == 0) return $signed(16'($urandom));
    return $signed(16'($urandom_range(0, 4095))) - 2048;
  endfunction

  task automatic random_command_step();
    int      r, idx;
    command_t c;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      // half the writes land on vertices already in use, clearing their sums
      idx = ($urandom_range(0, 1) == 0) ? pick_live() : $urandom_range(0, VERTEX_COUNT - 1);
      write_vertex(idx, random_coord(), random_coord(), random_coord());
    end else if (r < 62) begin
      add_triangle(pick_live(), pick_live(), pick_live());
    end else if (r < 94) begin
      read_normal(pick_live());
    end else begin
      send(random_command(CMD_NOP));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes of position and index
    write_vertex(0, -32768, -32768, -32768);
    write_vertex(1023, 32767, 32767, 32767);
    write_vertex(512, 32767, -32768, 0);
    write_vertex(341, -32768, 32767, 32767);
    write_vertex(682, 0, 0, 0);
    read_normal(0);                 // fresh vertex, zero sum, degenerate
    add_triangle(0, 512, 341);      // largest edges
    add_triangle(1023, 1023, 1023); // all corners equal, zero normal
    add_triangle(0, 0, 682);        // collinear, zero normal
    add_triangle(682, 1023, 512);
    read_normal(0);
    read_normal(512);
    read_normal(341);
    read_normal(1023);
    read_normal(682);
    send(random_command(CMD_NOP));
    add_triangle(0, 341, 512);      // reversed winding cancels the first sum
    read_normal(0);
    write_vertex(512, 1, 2, 3);     // rewrite clears the accumulator
    read_normal(512);
    add_triangle(512, 341, 1023);
    read_normal(512);
    read_normal(1023);

    // random phases: no idling, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 47 : (ph == 3) ? 31 : 0;
      recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 31 : 0;
      for (int n = 0; n < 470; n++) random_command_step();
    end
    in_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: vertex_normal_accumulator_top.f
rtl/core/vna_pkg.sv
rtl/core/vna_ram.sv
rtl/core/vna_norm.sv
rtl/core/vertex_normal_accumulator_top.sv
tb/vna_checker.sv
tb/tb_vertex_normal_accumulator_top.sv
